>>> hw/rtl/grt_pkg.sv
// Shared types and constants for the grid region placement table.
// No dependencies; imported by every module of the block but grt_ram.
`default_nettype none

package grt_pkg;

  // field widths fixed by the request and result format
  localparam int unsigned PosW    = 4;
  localparam int unsigned SpanW   = 5;
  localparam int unsigned GridW   = 5;
  localparam int unsigned StatusW = 3;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned CountW  = 5;

  localparam logic [GridW-1:0] GRID_RESET = 5'd16;

  // one stored rectangle
  typedef struct packed {
    logic [PosW-1:0]  row;
    logic [PosW-1:0]  col;
    logic [SpanW-1:0] height;
    logic [SpanW-1:0] width;
  } rect_t;

  localparam int unsigned RectW = $bits(rect_t);

  typedef enum logic {
    ACT_ADD   = 1'b0,
    ACT_CLEAR = 1'b1
  } action_e;

  typedef enum logic {
    REG_GRID_ROWS    = 1'b0,
    REG_GRID_COLUMNS = 1'b1
  } cfg_idx_e;

  typedef enum logic [StatusW-1:0] {
    ST_PLACED  = 3'd0,
    ST_BOUNDS  = 3'd1,
    ST_OVERLAP = 3'd2,
    ST_FULL    = 3'd3,
    ST_CLEARED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_WRITE,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

>>> hw/rtl/grid_region_placement_table.sv
// Top level of the grid region placement table: sequencer, count and registers.
// Depends on grt_pkg, grt_ram and grt_span_unit.
`default_nettype none

// Takes one request at a time and answers each with one result item. A clear
// offers its result in the cycle after acceptance. An add first passes through
// a bounds check state, which sends a rejected add straight to the result. An
// add that passes the bounds test scans the stored rectangles through the single
// read port of the table RAM, one per cycle, and then writes its slot. A full
// table answers at the end of the scan, without a write. The scan ends early at
// the first overlap. The input side stalls from acceptance until the result has
// been taken. Grid registers may be written only while no request is in flight.
module grid_region_placement_table
  import grt_pkg::*;
#(
  parameter int unsigned MAX_RECTS = 16,
  parameter int unsigned MAX_GRID  = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [GridW-1:0]   cfg_data_i,
  // request channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               action_i,
  input  wire logic [PosW-1:0]    origin_row_i,
  input  wire logic [PosW-1:0]    origin_column_i,
  input  wire logic [SpanW-1:0]   height_cells_i,
  input  wire logic [SpanW-1:0]   width_cells_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [StatusW-1:0] status_o,
  output logic      [SlotW-1:0]   slot_index_o,
  output logic      [CountW-1:0]  item_count_o
);

  localparam int unsigned AddrW   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int unsigned CntW    = $clog2(MAX_RECTS + 1);
  localparam int unsigned GridCap = (MAX_GRID > 31) ? 31 : MAX_GRID;
  localparam logic [CntW-1:0]  CountFull = CntW'(MAX_RECTS);
  localparam logic [GridW-1:0] GridMax   = GridW'(GridCap);

  state_e            state_q, state_d;
  logic [GridW-1:0]  rows_q, cols_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   issue_q, issue_d;
  logic              pend_q, pend_d;
  rect_t             req_q, req_d;
  status_e           res_status_q, res_status_d;
  logic [AddrW-1:0]  res_slot_q, res_slot_d;

  logic              in_acc;
  logic              more_entries;
  logic              bounds_bad;
  logic [GridW-1:0]  rows_eff, cols_eff;
  logic              ram_we, ram_re;
  logic [RectW-1:0]  ram_rdata;
  rect_t             entry;
  logic              hit;
  logic [31:0]       slot_wide, count_wide;

  assign in_acc       = in_valid_i && !in_stall_o;
  assign more_entries = issue_q < count_q;

  // bounds test with grid registers saturated
  assign rows_eff   = (rows_q > GridMax) ? GridMax : rows_q;
  assign cols_eff   = (cols_q > GridMax) ? GridMax : cols_q;
  assign bounds_bad = (req_q.height == '0) || (req_q.width == '0) ||
                      (({1'b0, SpanW'(req_q.row)} + {1'b0, req_q.height}) >
                       {1'b0, rows_eff}) ||
                      (({1'b0, SpanW'(req_q.col)} + {1'b0, req_q.width}) >
                       {1'b0, cols_eff});

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= GRID_RESET;
      cols_q <= GRID_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_GRID_ROWS:    rows_q <= cfg_data_i;
        REG_GRID_COLUMNS: cols_q <= cfg_data_i;
        default:          rows_q <= rows_q;
      endcase
    end
  end

  // rectangle table
  assign ram_re = (state_q == S_SCAN) && more_entries;
  assign ram_we = (state_q == S_WRITE);
  assign entry  = rect_t'(ram_rdata);

  grt_ram #(
    .Width (RectW),
    .Depth (MAX_RECTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (req_q),
    .re_i    (ram_re),
    .raddr_i (issue_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // overlap comparator shared by every scanned entry
  grt_span_unit u_span (
    .req_i   (req_q),
    .entry_i (entry),
    .hit_o   (hit)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (action_e'(action_i) == ACT_CLEAR) ? S_RESP : S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = bounds_bad ? S_RESP : S_SCAN;
      end
      S_SCAN: begin
        if (pend_q && hit) begin
          state_d = S_RESP;
        end else if (!more_entries && !pend_q) begin
          state_d = (count_q == CountFull) ? S_RESP : S_WRITE;
        end
      end
      S_WRITE: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and result updates
  always_comb begin
    count_d      = count_q;
    issue_d      = issue_q;
    pend_d       = 1'b0;
    req_d        = req_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          req_d      = '{row: origin_row_i, col: origin_column_i,
                         height: height_cells_i, width: width_cells_i};
          res_slot_d = '0;
          issue_d    = '0;
          if (action_e'(action_i) == ACT_CLEAR) begin
            count_d      = '0;
            res_status_d = ST_CLEARED;
          end
        end
      end
      S_CHECK: begin
        if (bounds_bad) begin
          res_status_d = ST_BOUNDS;
        end
      end
      S_SCAN: begin
        if (more_entries) begin
          issue_d = issue_q + 1'b1;
          pend_d  = 1'b1;
        end
        if (pend_q && hit) begin
          res_status_d = ST_OVERLAP;
          pend_d       = 1'b0;
        end else if (!more_entries && !pend_q) begin
          res_status_d = ST_FULL;
        end
      end
      S_WRITE: begin
        res_status_d = ST_PLACED;
        res_slot_d   = count_q[AddrW-1:0];
        count_d      = count_q + 1'b1;
      end
      S_RESP: begin
        res_status_d = res_status_q;
      end
      default: begin
        res_status_d = res_status_q;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      issue_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      issue_q <= issue_d;
      pend_q  <= pend_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
  end

  // ports
  assign slot_wide    = 32'(res_slot_q);
  assign count_wide   = 32'(count_q);
  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = (state_q == S_RESP);
  assign status_o     = res_status_q;
  assign slot_index_o = slot_wide[SlotW-1:0];
  assign item_count_o = count_wide[CountW-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/grt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; holds the rectangle table.
`default_nettype none

module grt_ram #(
  parameter int unsigned Width = 18,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/grt_span_unit.sv
// Shared overlap comparator: tests one stored rectangle against the request.
// Depends on grt_pkg for the rectangle type.
`default_nettype none

module grt_span_unit
  import grt_pkg::*;
(
  input  wire rect_t req_i,
  input  wire rect_t entry_i,
  output logic       hit_o
);

  logic [SpanW:0] req_row_end, req_col_end, ent_row_end, ent_col_end;
  logic           row_meet, col_meet;

  // half-open interval ends
  assign req_row_end = {1'b0, SpanW'(req_i.row)} + {1'b0, req_i.height};
  assign req_col_end = {1'b0, SpanW'(req_i.col)} + {1'b0, req_i.width};
  assign ent_row_end = {1'b0, SpanW'(entry_i.row)} + {1'b0, entry_i.height};
  assign ent_col_end = {1'b0, SpanW'(entry_i.col)} + {1'b0, entry_i.width};

  // intervals meet on both axes
  assign row_meet = ((SpanW + 1)'(req_i.row) < ent_row_end) &&
                    ((SpanW + 1)'(entry_i.row) < req_row_end);
  assign col_meet = ((SpanW + 1)'(req_i.col) < ent_col_end) &&
                    ((SpanW + 1)'(entry_i.col) < req_col_end);
  assign hit_o    = row_meet && col_meet;

endmodule

`default_nettype wire

>>> hw/rtl/grt_checker.sv
// Port-level checks for the grid region placement table, bound to the top.
// Depends on grt_pkg for status codes and field widths.
`default_nettype none

module grt_checker
  import grt_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [StatusW-1:0] status_o,
  input wire logic [SlotW-1:0]   slot_index_o,
  input wire logic [CountW-1:0]  item_count_o
);

  // one item in flight: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepting an item");

  // no new item while a result waits
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result is pending");

  // held result stays put
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(slot_index_o) &&
       $stable(item_count_o)))
    else $error("stalled result changed");

  // a clear leaves nothing stored
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_CLEARED) |->
      (item_count_o == '0 && slot_index_o == '0))
    else $error("clear result with nonzero slot or count");

  // rejected adds report slot zero
  a_reject_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_BOUNDS || status_o == ST_OVERLAP ||
                     status_o == ST_FULL)) |-> slot_index_o == '0)
    else $error("rejected add with nonzero slot");

endmodule

bind grid_region_placement_table grt_checker u_grt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .slot_index_o (slot_index_o),
  .item_count_o (item_count_o)
);

`default_nettype wire

>>> bench/grid_region_placement_table_test.sv
`timescale 1ns / 1ps
// Self-checking bench for grid_region_placement_table: directed and random requests,
// predicted in-house and compared field by field. Depends on grt_pkg and the RTL top.
module grid_region_placement_table_test;
  import grt_pkg::*;

  localparam int unsigned MaxRects      = 16;
  localparam int unsigned MaxGrid       = 16;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldoffCycles = 200;
  localparam int unsigned ReportCap     = 60;

  typedef struct {
    action_e          action;
    logic [PosW-1:0]  row;
    logic [PosW-1:0]  col;
    logic [SpanW-1:0] height;
    logic [SpanW-1:0] width;
  } request_t;

  typedef struct {
    status_e           status;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] count;
  } answer_t;

  // clock, reset and block ports
  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic               cfg_idx_i       = 1'b0;
  logic [GridW-1:0]   cfg_data_i      = '0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic               action_i        = 1'b0;
  logic [PosW-1:0]    origin_row_i    = '0;
  logic [PosW-1:0]    origin_column_i = '0;
  logic [SpanW-1:0]   height_cells_i  = '0;
  logic [SpanW-1:0]   width_cells_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [SlotW-1:0]   slot_index_o;
  logic [CountW-1:0]  item_count_o;

  // own copy of the placement state and grid registers
  rect_t            placed_rects [MaxRects];
  int unsigned      placed_count  = 0;
  logic [GridW-1:0] grid_rows_cfg = GRID_RESET;
  logic [GridW-1:0] grid_cols_cfg = GRID_RESET;

  answer_t     expected_answers [$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_stall_pct   = 0;
  bit          holding_off    = 1'b0;
  event        holdoff_go;

  grid_region_placement_table i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .origin_row_i    (origin_row_i),
    .origin_column_i (origin_column_i),
    .height_cells_i  (height_cells_i),
    .width_cells_i   (width_cells_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .slot_index_o    (slot_index_o),
    .item_count_o    (item_count_o)
  );

  always #5 clk_i = ~clk_i;

  // grid register as the block sees it: saturated at the largest grid
  function automatic int unsigned grid_limit(logic [GridW-1:0] g);
    return (g > MaxGrid) ? MaxGrid : int'(g);
  endfunction

  // works out the answer to one request and updates the table copy
  function automatic answer_t predict_placement(request_t req);
    answer_t     ans;
    int unsigned r_lim, c_lim, idx;
    int unsigned r, c, h, w, er, ec, eh, ew;
    bit          hit;
    ans.status = ST_PLACED;
    ans.slot   = '0;
    r = req.row;
    c = req.col;
    h = req.height;
    w = req.width;
    r_lim = grid_limit(grid_rows_cfg);
    c_lim = grid_limit(grid_cols_cfg);
    hit = 1'b0;
    if (req.action == ACT_CLEAR) begin
      placed_count = 0;
      ans.status = ST_CLEARED;
    end else if (h == 0 || w == 0 || r + h > r_lim || c + w > c_lim) begin
      ans.status = ST_BOUNDS;
    end else begin
      // half-open intervals have to meet on both axes to collide
      for (idx = 0; idx < placed_count; idx++) begin
        er = placed_rects[idx].row;
        ec = placed_rects[idx].col;
        eh = placed_rects[idx].height;
        ew = placed_rects[idx].width;
        if (r < er + eh && er < r + h && c < ec + ew && ec < c + w) hit = 1'b1;
      end
      if (hit) begin
        ans.status = ST_OVERLAP;
      end else if (placed_count >= MaxRects) begin
        ans.status = ST_FULL;
      end else begin
        ans.slot = SlotW'(placed_count);
        placed_rects[placed_count] = '{row: req.row, col: req.col,
                                       height: req.height, width: req.width};
        placed_count++;
      end
    end
    ans.count = CountW'(placed_count);
    return ans;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= ReportCap) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // result side: random stall, forced high during a hold-off
  always @(posedge clk_i) begin
    out_stall_i <= holding_off || ($urandom_range(99) < rx_stall_pct);
  end

  // long receiver hold-off, counted here
  always begin
    @(holdoff_go);
    holding_off = 1'b1;
    repeat (HoldoffCycles) @(posedge clk_i);
    holding_off = 1'b0;
  end

  // compare each result item with the oldest expectation
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("result item with no request outstanding");
      end else begin
        want = expected_answers.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        if (slot_index_o !== want.slot)
          report_mismatch($sformatf("slot_index %0d, expected %0d", slot_index_o, want.slot));
        if (item_count_o !== want.count)
          report_mismatch($sformatf("item_count %0d, expected %0d", item_count_o, want.count));
      end
    end
  end

  // watchdog on cycles without any handshake or register write
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one item after a random gap and record its expected answer on acceptance
  task automatic send_request(request_t req);
    answer_t ans;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= req.action;
    origin_row_i    <= req.row;
    origin_column_i <= req.col;
    height_cells_i  <= req.height;
    width_cells_i   <= req.width;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    ans = predict_placement(req);
    expected_answers.insert(expected_answers.size(), ans);
  endtask

  task automatic send_add(int unsigned r, int unsigned c, int unsigned h, int unsigned w);
    request_t req;
    req = '{action: ACT_ADD, row: PosW'(r), col: PosW'(c),
            height: SpanW'(h), width: SpanW'(w)};
    send_request(req);
  endtask

  task automatic send_clear();
    request_t req;
    req = '{action: ACT_CLEAR, row: PosW'($urandom), col: PosW'($urandom),
            height: SpanW'($urandom), width: SpanW'($urandom)};
    send_request(req);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_grid(cfg_idx_e idx, logic [GridW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx == REG_GRID_ROWS) grid_rows_cfg = value;
    else grid_cols_cfg = value;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [GridW-1:0] pick_grid_size();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return GridW'(MaxGrid);
      5, 6, 7:       return GridW'($urandom_range(1, MaxGrid));
      8:             return GridW'($urandom_range(MaxGrid + 1, 31));
      default:       return GridW'($urandom_range(0, 2));
    endcase
  endfunction

  // mostly rectangles that fit the grid, some clears and some raw noise
  function automatic request_t make_request();
    request_t    req;
    int unsigned r_lim, c_lim, pick, h_top, w_top;
    r_lim = grid_limit(grid_rows_cfg);
    c_lim = grid_limit(grid_cols_cfg);
    pick = $urandom_range(99);
    req.action = ACT_ADD;
    req.row    = PosW'($urandom);
    req.col    = PosW'($urandom);
    req.height = SpanW'($urandom);
    req.width  = SpanW'($urandom);
    if (pick < 4 || (placed_count == MaxRects && pick < 30)) begin
      req.action = ACT_CLEAR;
    end else if (pick < 88 && r_lim != 0 && c_lim != 0) begin
      h_top = ($urandom_range(3) == 0 || r_lim < 3) ? r_lim : 3;
      w_top = ($urandom_range(3) == 0 || c_lim < 3) ? c_lim : 3;
      req.height = SpanW'($urandom_range(1, h_top));
      req.width  = SpanW'($urandom_range(1, w_top));
      req.row    = PosW'($urandom_range(0, r_lim - req.height));
      req.col    = PosW'($urandom_range(0, c_lim - req.width));
    end
    return req;
  endfunction

  // zero spans, whole grid, touching corners, overflowing spans
  task automatic test_directed_edges();
    send_clear();
    send_add(0, 0, 0, 5);
    send_add(3, 3, 5, 0);
    send_add(0, 0, 16, 16);
    send_add(15, 15, 1, 1);
    send_clear();
    send_add(15, 15, 1, 1);
    send_add(0, 0, 15, 15);
    send_add(14, 14, 2, 2);
    send_add(0, 0, 31, 31);
    send_add(15, 0, 1, 31);
    send_add(0, 15, 17, 1);
    send_add(15, 15, 2, 1);
  endtask

  // sixteen single cells, then one more of each rejection kind
  task automatic test_table_full();
    int unsigned col;
    send_clear();
    for (col = 0; col < MaxRects; col++) send_add(0, col, 1, 1);
    send_add(5, 5, 1, 1);
    send_add(0, 3, 1, 1);
    send_add(15, 15, 2, 2);
    send_clear();
  endtask

  // smallest grid, zero grid, saturated grid
  task automatic test_grid_registers();
    wait_drained();
    write_grid(REG_GRID_ROWS, 5'd1);
    write_grid(REG_GRID_COLUMNS, 5'd1);
    send_clear();
    send_add(0, 0, 1, 1);
    send_add(0, 0, 1, 2);
    send_add(0, 1, 1, 1);
    wait_drained();
    write_grid(REG_GRID_ROWS, 5'd0);
    send_add(0, 0, 1, 1);
    wait_drained();
    write_grid(REG_GRID_ROWS, 5'd16);
    write_grid(REG_GRID_COLUMNS, 5'd0);
    send_add(0, 0, 1, 1);
    wait_drained();
    write_grid(REG_GRID_ROWS, 5'd31);
    write_grid(REG_GRID_COLUMNS, 5'd31);
    send_clear();
    send_add(0, 0, 16, 16);
    send_add(0, 0, 17, 1);
    send_clear();
    wait_drained();
    write_grid(REG_GRID_ROWS, GRID_RESET);
    write_grid(REG_GRID_COLUMNS, GRID_RESET);
  endtask

  task automatic test_random_traffic(int unsigned n_items, int unsigned tx_pct,
                                     int unsigned rx_pct);
    int unsigned sent;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      wait_drained();
      write_grid(REG_GRID_ROWS, pick_grid_size());
      write_grid(REG_GRID_COLUMNS, pick_grid_size());
      repeat (40) send_request(make_request());
      sent += 40;
    end
  endtask

  // receiver holds off while the sender keeps offering items back to back
  task automatic test_receiver_holdoff();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    wait_drained();
    -> holdoff_go;
    repeat (8) send_request(make_request());
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct  = 35;
    rx_stall_pct = 68;
    test_directed_edges();
    test_table_full();
    test_grid_registers();
    test_random_traffic(200, 35, 68);
    test_random_traffic(200, 68, 35);
    test_receiver_holdoff();
    test_random_traffic(120, 0, 0);
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/grt_pkg.sv
hw/rtl/grt_ram.sv
hw/rtl/grt_span_unit.sv
hw/rtl/grid_region_placement_table.sv
hw/rtl/grt_checker.sv
bench/grid_region_placement_table_test.sv
